>>> rtl/tbpr_pkg.sv
// ---------------------------------------------------------------------------
// tbpr_pkg
// Shared types and constants for the tile background pixel renderer.
// ---------------------------------------------------------------------------
package tbpr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 160;
  localparam int unsigned SCREEN_HEIGHT = 144;
  localparam int unsigned VRAM_BYTES    = 8192;
  localparam int unsigned VRAM_AW       = 13;

  localparam logic [VRAM_AW-1:0] SIGNED_TILE_MID = 13'h0800;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_SCROLL_X  = 2'd0,
    CFG_SCROLL_Y  = 2'd1,
    CFG_MAP_SEL   = 2'd2,
    CFG_TILE_SEL  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_LO   = 4'b0100,
    S_HI   = 4'b1000
  } state_t;

endpackage

>>> rtl/tbpr_if.sv
// ---------------------------------------------------------------------------
// tbpr_in_if / tbpr_out_if
// Valid/ready channels for commands in and rendered pixels out.
// ---------------------------------------------------------------------------
interface tbpr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [12:0] ram_address;
  logic [7:0]  ram_data;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;

  modport source (output valid, command, ram_address, ram_data, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, command, ram_address, ram_data, pixel_x, pixel_y,
                  output ready);
endinterface

interface tbpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [1:0] color;

  modport source (output valid, out_x, out_y, color, input ready);
  modport sink   (input valid, out_x, out_y, color, output ready);
endinterface

>>> rtl/tile_background_pixel_renderer_unit.sv
// ---------------------------------------------------------------------------
// tile_background_pixel_renderer_unit
// Video RAM with a tile map background lookup, one pixel colour per render.
// ---------------------------------------------------------------------------
// A write transaction stores one byte into the 8 KiB video RAM in the cycle it
// is accepted and gives no result. A render moves through the map, low and high
// states to the result register: the single read port of the video RAM serves
// three dependent reads in turn (tile map byte, then the two bytes of the tile
// row). The input is ready again once the pixel is registered, so a render is
// not taken before the last one is done, and later still while a full output
// register is held off. Off-screen render requests are dropped on acceptance.
// New transactions are taken only when no render is in flight; a finished
// pixel waits in the output register while the next transaction is taken.
// Video RAM has no reset and must be written before it is read.
module tile_background_pixel_renderer_unit
  import tbpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tbpr_in_if.sink           in_chan,
  tbpr_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0] scroll_x_r, scroll_y_r;
  logic       map_sel_r, tile_sel_r;

  state_t state_r, state_nxt;

  logic [7:0]         vram [VRAM_BYTES];
  logic [7:0]         rd_data_r;
  logic               rd_en;
  logic [VRAM_AW-1:0] rd_addr;
  logic               vram_we;

  logic [7:0]         x_r, y_r, px_r, py_r;
  logic [VRAM_AW-1:0] line_addr_r, line_addr_nxt;
  logic               b0_r;

  logic               out_valid_r;
  logic [7:0]         out_x_r, out_y_r;
  logic [1:0]         color_r;

  logic       in_fire, on_screen, render_go, out_free;
  logic [7:0] sx, sy;
  logic [VRAM_AW-1:0] tile_addr;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= '0;
      scroll_y_r <= '0;
      map_sel_r  <= 1'b0;
      tile_sel_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCROLL_X: scroll_x_r <= cfg_wdata;
        CFG_SCROLL_Y: scroll_y_r <= cfg_wdata;
        CFG_MAP_SEL:  map_sel_r  <= cfg_wdata[0];
        CFG_TILE_SEL: tile_sel_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign on_screen = ({1'b0, in_chan.pixel_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, in_chan.pixel_y} < 9'(SCREEN_HEIGHT));
  assign render_go = in_fire && (cmd_t'(in_chan.command) == CMD_RENDER) && on_screen;
  assign vram_we   = in_fire && (cmd_t'(in_chan.command) == CMD_WRITE);
  assign out_free  = !out_valid_r || out_chan.ready;

  assign sx = in_chan.pixel_x + scroll_x_r;
  assign sy = in_chan.pixel_y + scroll_y_r;

  // tile base from the map byte now in the read register
  always_comb begin
    if (tile_sel_r) begin
      tile_addr = {1'b0, rd_data_r, 4'b0000};
    end else begin
      tile_addr = SIGNED_TILE_MID + {1'b0, ~rd_data_r[7], rd_data_r[6:0], 4'b0000};
    end
    line_addr_nxt = tile_addr | {9'd0, y_r[2:0], 1'b0};
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = line_addr_r;
    case (state_r)
      S_IDLE: begin
        rd_en   = render_go;
        rd_addr = {2'b11, map_sel_r, sy[7:3], sx[7:3]};
      end
      S_MAP: begin
        rd_en   = 1'b1;
        rd_addr = line_addr_nxt;
      end
      S_LO: begin
        rd_en   = 1'b1;
        rd_addr = line_addr_r | 13'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vram_we) begin
      vram[in_chan.ram_address] <= in_chan.ram_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vram[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (render_go) state_nxt = S_MAP;
      S_MAP:   state_nxt = S_LO;
      S_LO:    state_nxt = S_HI;
      S_HI:    if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_HI && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-pixel working registers
  always_ff @(posedge clk) begin
    if (render_go) begin
      x_r  <= sx;
      y_r  <= sy;
      px_r <= in_chan.pixel_x;
      py_r <= in_chan.pixel_y;
    end
    if (state_r == S_MAP) begin
      line_addr_r <= line_addr_nxt;
    end
    if (state_r == S_LO) begin
      b0_r <= rd_data_r[~x_r[2:0]];
    end
    if (state_r == S_HI && out_free) begin
      out_x_r <= px_r;
      out_y_r <= py_r;
      color_r <= {rd_data_r[~x_r[2:0]], b0_r};
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.out_x = out_x_r;
  assign out_chan.out_y = out_y_r;
  assign out_chan.color = color_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("render state not one-hot");

  a_map_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP) |-> $past(render_go))
    else $error("map lookup without an accepted render");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vram_we |-> (state_r == S_IDLE))
    else $error("video ram write during a render");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HI && out_free) |=> out_valid_r)
    else $error("finished pixel not presented");

  a_hi_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HI && !out_free) |=> (state_r == S_HI) && $stable(rd_data_r))
    else $error("stalled pixel lost its row byte");
`endif

endmodule
